### rtl/bcrf_pkg.sv
// ----------------------------------------------------------------------------
// bcrf_pkg: shared types and constants of the bisection cubic root finder
// Holds the field widths, the microcode word and its program, the status
// codes and the small fixed-point helpers used by the core.
// ----------------------------------------------------------------------------
package bcrf_pkg;

    localparam int IN_W      = 28;
    localparam int TOL_W     = 25;
    localparam int ITER_W    = 7;
    localparam int STAT_W    = 2;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 40;

    // Horner intermediate, saturated to +-2^35, needs 37 signed bits.
    localparam int T_W      = 37;
    localparam longint T_LIMIT = 64'sd34359738368;
    // The intermediate is multiplied in two segments on one shared multiplier.
    localparam int SEG_LO_W = 18;
    localparam int SEG_HI_W = T_W - SEG_LO_W;
    localparam int PROD_W   = SEG_HI_W + IN_W;
    localparam int ACC_W    = 66;

    localparam logic [TOL_W-1:0] TOL_RESET = 25'd17;

    localparam logic [STAT_W-1:0] ST_CONVERGED = 2'd0;
    localparam logic [STAT_W-1:0] ST_EXACT     = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_CHANGE = 2'd2;
    localparam logic [STAT_W-1:0] ST_CAP       = 2'd3;

    localparam int UPC_W = 5;
    localparam logic [UPC_W-1:0] UA_START    = 5'd0;
    localparam logic [UPC_W-1:0] UA_EVAL_MID = 5'd18;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_TINIT,   // t = sat(x - 2)
        OP_MLO,     // prod = t[low segment] * x
        OP_MHI,     // acc = prod; prod = t[high segment] * x
        OP_ADD,     // acc = acc + (prod << low segment width)
        OP_TNEXT,   // t = sat(floor(acc) - 4)
        OP_SIGN,    // sign of floor(acc) + 4 into the selected flag
        OP_DECIDE,  // narrow the interval or stop
        OP_CHECK    // new midpoint, convergence and cap tests
    } op_t;

    typedef enum logic [1:0] {
        PT_LO,
        PT_HI,
        PT_MID
    } pt_t;

    typedef struct packed {
        op_t              op;
        pt_t              pt;
        logic             jump;
        logic [UPC_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic neg;
        logic zero;
    } sgn_t;

    function automatic uword_t uw(input op_t op, input pt_t pt, input logic jump,
                                  input logic [UPC_W-1:0] target);
        uword_t w;
        w.op     = op;
        w.pt     = pt;
        w.jump   = jump;
        w.target = target;
        return w;
    endfunction

    // Program: evaluate f at low, at high, then loop on the midpoint.
    function automatic uword_t ucode_rom(input logic [UPC_W-1:0] addr);
        uword_t w;
        case (addr)
            5'd0:  w = uw(OP_TINIT,  PT_LO,  1'b0, UA_START);
            5'd1:  w = uw(OP_MLO,    PT_LO,  1'b0, UA_START);
            5'd2:  w = uw(OP_MHI,    PT_LO,  1'b0, UA_START);
            5'd3:  w = uw(OP_ADD,    PT_LO,  1'b0, UA_START);
            5'd4:  w = uw(OP_TNEXT,  PT_LO,  1'b0, UA_START);
            5'd5:  w = uw(OP_MLO,    PT_LO,  1'b0, UA_START);
            5'd6:  w = uw(OP_MHI,    PT_LO,  1'b0, UA_START);
            5'd7:  w = uw(OP_ADD,    PT_LO,  1'b0, UA_START);
            5'd8:  w = uw(OP_SIGN,   PT_LO,  1'b0, UA_START);
            5'd9:  w = uw(OP_TINIT,  PT_HI,  1'b0, UA_START);
            5'd10: w = uw(OP_MLO,    PT_HI,  1'b0, UA_START);
            5'd11: w = uw(OP_MHI,    PT_HI,  1'b0, UA_START);
            5'd12: w = uw(OP_ADD,    PT_HI,  1'b0, UA_START);
            5'd13: w = uw(OP_TNEXT,  PT_HI,  1'b0, UA_START);
            5'd14: w = uw(OP_MLO,    PT_HI,  1'b0, UA_START);
            5'd15: w = uw(OP_MHI,    PT_HI,  1'b0, UA_START);
            5'd16: w = uw(OP_ADD,    PT_HI,  1'b0, UA_START);
            5'd17: w = uw(OP_SIGN,   PT_HI,  1'b0, UA_START);
            5'd18: w = uw(OP_TINIT,  PT_MID, 1'b0, UA_START);
            5'd19: w = uw(OP_MLO,    PT_MID, 1'b0, UA_START);
            5'd20: w = uw(OP_MHI,    PT_MID, 1'b0, UA_START);
            5'd21: w = uw(OP_ADD,    PT_MID, 1'b0, UA_START);
            5'd22: w = uw(OP_TNEXT,  PT_MID, 1'b0, UA_START);
            5'd23: w = uw(OP_MLO,    PT_MID, 1'b0, UA_START);
            5'd24: w = uw(OP_MHI,    PT_MID, 1'b0, UA_START);
            5'd25: w = uw(OP_ADD,    PT_MID, 1'b0, UA_START);
            5'd26: w = uw(OP_SIGN,   PT_MID, 1'b0, UA_START);
            5'd27: w = uw(OP_DECIDE, PT_MID, 1'b0, UA_START);
            5'd28: w = uw(OP_CHECK,  PT_MID, 1'b1, UA_EVAL_MID);
            default: w = uw(OP_NONE, PT_LO,  1'b1, UA_START);
        endcase
        return w;
    endfunction

    // floor((a + b) / 2)
    function automatic logic signed [IN_W-1:0] midpoint(input logic signed [IN_W-1:0] a,
                                                       input logic signed [IN_W-1:0] b);
        logic signed [IN_W:0] s;
        s = (IN_W+1)'(a) + (IN_W+1)'(b);
        return s[IN_W:1];
    endfunction

    // True when both signs are nonzero and differ.
    function automatic logic opposite(input sgn_t a, input sgn_t b);
        return !a.zero && !b.zero && (a.neg != b.neg);
    endfunction

endpackage

### rtl/bisection_cubic_root_finder_core.sv
// ----------------------------------------------------------------------------
// bisection_cubic_root_finder_core: bisection search for a root of
// f(x) = x^3 - 2x^2 - 4x + 4 in signed fixed point
// One item on the slave side gives an interval; one item on the master side
// returns the final midpoint, the step count and a status.
// ----------------------------------------------------------------------------
// One input item is processed at a time. Each evaluation of f runs as nine
// microcode steps on a single shared 19x28 multiplier. An item first evaluates
// f at both interval ends once; each bisection step then evaluates f at the
// midpoint and updates the interval, and the core returns to idle after the
// last step. There are at most MAX_ITERS bisection steps per item. A new item
// is taken while the previous result still waits in the output register; the
// core only stalls at the end of a search if that register is still full. The
// tolerance register is written with cfg_we and cfg_wdata; the user must write
// it only while the core is idle, the core itself does not enforce this.
module bisection_cubic_root_finder_core #(
    parameter int MAX_ITERS = 48,
    parameter int FRAC_BITS = 24
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [bcrf_pkg::TOL_W-1:0]        cfg_wdata,   // tolerance
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bcrf_pkg::S_TDATA_W-1:0]    s_tdata,     // interval_low, interval_high
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bcrf_pkg::M_TDATA_W-1:0]    m_tdata      // root, iterations, status, pad
);
    import bcrf_pkg::*;

    localparam int P_W = ACC_W - FRAC_BITS + 1;
    localparam logic signed [P_W-1:0] TWO_P   = P_W'(2) << FRAC_BITS;
    localparam logic signed [P_W-1:0] FOUR_P  = P_W'(4) << FRAC_BITS;
    localparam logic signed [P_W-1:0] T_LIM_P = P_W'(T_LIMIT);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic signed [IN_W-1:0]   lo_reg, hi_reg, mid_reg, x_reg;
    logic signed [T_W-1:0]    t_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    sgn_t                     sl_reg, sh_reg, sm_reg;
    logic [ITER_W-1:0]        n_reg;
    logic [TOL_W-1:0]         tol_reg;
    logic                     m_valid_reg;
    logic [M_TDATA_W-1:0]     m_data_reg;

    uword_t                   ctrl;
    logic                     accept, run, adv, finish;
    logic signed [IN_W-1:0]   x_src, mid_new;
    logic signed [P_W-1:0]    acc_sh, sat_in, t_sat, sign_v;
    logic signed [SEG_HI_W-1:0] seg;
    logic signed [PROD_W-1:0] mul;
    logic signed [IN_W:0]     diff;
    logic [IN_W:0]            width;
    logic                     conv, cap, take_hi, take_lo;
    sgn_t                     sgn_new;
    logic [STAT_W-1:0]        res_status;
    logic signed [IN_W-1:0]   res_root;
    logic [ITER_W-1:0]        res_iter;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign run      = (state_reg == S_RUN);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    bcrf_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .step    (run && adv),
        .ctrl    (ctrl)
    );

    // Shared fixed-point datapath
    always_comb begin
        case (ctrl.pt)
            PT_LO:   x_src = lo_reg;
            PT_HI:   x_src = hi_reg;
            default: x_src = mid_reg;
        endcase

        acc_sh = P_W'(acc_reg >>> FRAC_BITS);
        if (ctrl.op == OP_TINIT) begin
            sat_in = P_W'(x_src) - TWO_P;
        end else begin
            sat_in = acc_sh - FOUR_P;
        end
        if (sat_in > T_LIM_P) begin
            t_sat = T_LIM_P;
        end else if (sat_in < -T_LIM_P) begin
            t_sat = -T_LIM_P;
        end else begin
            t_sat = sat_in;
        end

        sign_v       = acc_sh + FOUR_P;
        sgn_new.neg  = sign_v < 0;
        sgn_new.zero = sign_v == 0;

        // The low segment is unsigned, so it enters the multiplier with a zero on top.
        if (ctrl.op == OP_MLO) begin
            seg = $signed({1'b0, t_reg[SEG_LO_W-1:0]});
        end else begin
            seg = t_reg[T_W-1:SEG_LO_W];
        end
        mul = seg * x_reg;
    end

    // Interval update and end-of-search tests
    always_comb begin
        take_hi = opposite(sm_reg, sl_reg);
        take_lo = !take_hi && opposite(sm_reg, sh_reg);
        mid_new = midpoint(lo_reg, hi_reg);
        diff    = (IN_W+1)'(hi_reg) - (IN_W+1)'(lo_reg);
        width   = diff[IN_W] ? unsigned'(-diff) : unsigned'(diff);
        conv    = width < (IN_W+1)'(tol_reg);
        cap     = n_reg >= ITER_W'(MAX_ITERS);

        finish     = 1'b0;
        res_status = ST_CAP;
        res_root   = mid_reg;
        res_iter   = n_reg;
        case (ctrl.op)
            OP_DECIDE: begin
                finish     = !take_hi && !take_lo;
                res_status = sm_reg.zero ? ST_EXACT : ST_NO_CHANGE;
                res_iter   = n_reg + ITER_W'(1);
            end
            OP_CHECK: begin
                finish     = conv || cap;
                res_status = conv ? ST_CONVERGED : ST_CAP;
                res_root   = mid_new;
            end
            default: begin
                finish = 1'b0;
            end
        endcase
        adv = !(finish && m_valid_reg && !m_tready);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_RUN;
            S_RUN:   if (finish && adv) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            tol_reg     <= TOL_RESET;
            lo_reg      <= '0;
            hi_reg      <= '0;
            n_reg       <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                tol_reg <= cfg_wdata;
            end
            if (run && finish && adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept) begin
                lo_reg <= s_tdata[IN_W-1:0];
                hi_reg <= s_tdata[2*IN_W-1:IN_W];
                n_reg  <= '0;
            end else if (run && adv && ctrl.op == OP_DECIDE) begin
                n_reg <= n_reg + ITER_W'(1);
                if (take_hi) begin
                    hi_reg <= mid_reg;
                end else if (take_lo) begin
                    lo_reg <= mid_reg;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            mid_reg <= midpoint(s_tdata[IN_W-1:0], s_tdata[2*IN_W-1:IN_W]);
        end else if (run && adv) begin
            if (finish) begin
                m_data_reg <= {{(M_TDATA_W-IN_W-ITER_W-STAT_W){1'b0}},
                               res_status, res_iter, res_root};
            end
            case (ctrl.op)
                OP_TINIT: begin
                    x_reg <= x_src;
                    t_reg <= t_sat[T_W-1:0];
                end
                OP_MLO: begin
                    prod_reg <= mul;
                end
                OP_MHI: begin
                    acc_reg  <= ACC_W'(prod_reg);
                    prod_reg <= mul;
                end
                OP_ADD: begin
                    acc_reg <= acc_reg + (ACC_W'(prod_reg) <<< SEG_LO_W);
                end
                OP_TNEXT: begin
                    t_reg <= t_sat[T_W-1:0];
                end
                OP_SIGN: begin
                    case (ctrl.pt)
                        PT_LO:   sl_reg <= sgn_new;
                        PT_HI:   sh_reg <= sgn_new;
                        default: sm_reg <= sgn_new;
                    endcase
                end
                OP_DECIDE: begin
                    // The moved end takes over the midpoint's sign, so f is not re-evaluated there.
                    if (take_hi) begin
                        sh_reg <= sm_reg;
                    end else if (take_lo) begin
                        sl_reg <= sm_reg;
                    end
                end
                OP_CHECK: begin
                    mid_reg <= mid_new;
                end
                default: begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
    end

endmodule

### rtl/bcrf_useq.sv
// ----------------------------------------------------------------------------
// bcrf_useq: microcode sequencer
// Step counter over the program table; advances or jumps on each enabled
// cycle and restarts at the first step when a new item begins.
// ----------------------------------------------------------------------------
module bcrf_useq (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic            step,
    output bcrf_pkg::uword_t ctrl
);
    import bcrf_pkg::*;

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;

    assign ctrl = ucode_rom(upc_reg);

    always_comb begin
        upc_next = upc_reg;
        if (start) begin
            upc_next = UA_START;
        end else if (step) begin
            upc_next = ctrl.jump ? ctrl.target : upc_reg + UPC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= UA_START;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

### rtl/bcrf_checker.sv
// ----------------------------------------------------------------------------
// bcrf_checker: port-level assertions for the root finder core
// Watches the result channel and checks the step count against the status.
// ----------------------------------------------------------------------------
module bcrf_checker #(
    parameter int MAX_ITERS = 48
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [bcrf_pkg::M_TDATA_W-1:0] m_tdata
);
    import bcrf_pkg::*;

    logic [ITER_W-1:0] iter_f;
    logic [STAT_W-1:0] stat_f;

    assign iter_f = m_tdata[IN_W+ITER_W-1:IN_W];
    assign stat_f = m_tdata[IN_W+ITER_W+STAT_W-1:IN_W+ITER_W];

    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    a_data_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result item changed while stalled");

    a_iter_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (iter_f != '0) && (iter_f <= ITER_W'(MAX_ITERS)))
        else $error("step count out of range");

    a_cap_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (stat_f == ST_CAP) |-> (iter_f == ITER_W'(MAX_ITERS)))
        else $error("iteration cap reported before the cap");

endmodule

bind bisection_cubic_root_finder_core bcrf_checker #(
    .MAX_ITERS(MAX_ITERS)
) u_bcrf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/tb_bisection_cubic_root_finder_core.sv
// ----------------------------------------------------------------------------
// tb_bisection_cubic_root_finder_core: self-checking bench for the root finder
// Sends search intervals on the slave stream and compares every returned
// root, step count and status with a bisection search that the bench runs
// itself. Directed intervals come first, then random ones under several
// tolerance settings, with random idle cycles on both streams.
// ----------------------------------------------------------------------------
module tb_bisection_cubic_root_finder_core;
    import bcrf_pkg::*;

    localparam int     CLK_PERIOD         = 10;
    localparam int     MAX_ITERS          = 48;
    localparam int     FRAC_BITS          = 24;
    localparam int     MAX_GAP            = 19;
    localparam int     BUSY_CYCLES        = 19 + 11 * MAX_ITERS;
    localparam int     WATCHDOG_LIMIT     = 4 * (BUSY_CYCLES + 2 * MAX_GAP);
    localparam int     ITEMS_PER_PHASE    = 116;
    localparam longint ONE                = longint'(1) << FRAC_BITS;
    localparam longint FIELD_MIN          = -134217728;
    localparam longint FIELD_MAX          = 134217727;

    typedef struct {
        logic [IN_W-1:0]   root;
        logic [ITER_W-1:0] iters;
        logic [STAT_W-1:0] status;
    } root_result_t;

    class root_scoreboard;
        logic [TOL_W-1:0]  tolerance;
        longint            work_low;
        longint            work_high;
        logic [ITER_W-1:0] step_count;
        root_result_t      expected_roots[$];
        int                mismatches;

        function new();
            tolerance  = TOL_RESET;
            work_low   = 0;
            work_high  = 0;
            step_count = '0;
            mismatches = 0;
        endfunction

        function void set_tolerance(logic [TOL_W-1:0] value);
            tolerance = value;
        endfunction

        function int outstanding();
            return expected_roots.size();
        endfunction

        static function longint clamp_t(longint v);
            if (v > T_LIMIT) return T_LIMIT;
            if (v < -T_LIMIT) return -T_LIMIT;
            return v;
        endfunction

        // Sign of ((x - 2)x - 4)x + 4 with every product floored back to the
        // fixed-point grid.
        function int f_sign(longint x);
            longint t;
            longint p;
            t = clamp_t(x - 2 * ONE);
            p = (t * x) >>> FRAC_BITS;
            t = clamp_t(p - 4 * ONE);
            p = ((t * x) >>> FRAC_BITS) + 4 * ONE;
            return (p > 0) ? 1 : ((p < 0) ? -1 : 0);
        endfunction

        function root_result_t search_root(logic [IN_W-1:0] lo_bits,
                                           logic [IN_W-1:0] hi_bits);
            logic signed [IN_W-1:0] lo_s;
            logic signed [IN_W-1:0] hi_s;
            longint            lo;
            longint            hi;
            longint            mid;
            longint            width;
            int                n;
            int                sm;
            int                sl;
            int                sh;
            bit                done;
            logic [STAT_W-1:0] status;
            root_result_t      r;
            lo_s   = lo_bits;
            hi_s   = hi_bits;
            lo     = longint'(lo_s);
            hi     = longint'(hi_s);
            mid    = (lo + hi) >>> 1;
            n      = 0;
            done   = 1'b0;
            status = ST_CAP;
            while (!done) begin
                n++;
                sm = f_sign(mid);
                sl = f_sign(lo);
                sh = f_sign(hi);
                if (sm * sl < 0) begin
                    hi = mid;
                end else if (sm * sh < 0) begin
                    lo = mid;
                end else begin
                    // Neither end brackets the midpoint: it is a root, or the
                    // interval has no sign change at all.
                    status = (sm == 0) ? ST_EXACT : ST_NO_CHANGE;
                    done   = 1'b1;
                end
                if (!done) begin
                    mid   = (lo + hi) >>> 1;
                    width = (hi > lo) ? hi - lo : lo - hi;
                    if (width < longint'(tolerance)) begin
                        status = ST_CONVERGED;
                        done   = 1'b1;
                    end else if (n >= MAX_ITERS) begin
                        status = ST_CAP;
                        done   = 1'b1;
                    end
                end
            end
            work_low   = lo;
            work_high  = hi;
            step_count = n[ITER_W-1:0];
            r.root     = mid[IN_W-1:0];
            r.iters    = n[ITER_W-1:0];
            r.status   = status;
            return r;
        endfunction

        function void note_interval(logic [IN_W-1:0] lo, logic [IN_W-1:0] hi);
            expected_roots.push_back(search_root(lo, hi));
        endfunction

        function void report_mismatch(string field, longint want, longint got);
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, field, want, got);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data);
            root_result_t want;
            root_result_t got;
            got.root   = data[0 +: IN_W];
            got.iters  = data[IN_W +: ITER_W];
            got.status = data[IN_W+ITER_W +: STAT_W];
            if (expected_roots.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result: expected none, actual %h", $time, data);
                return;
            end
            want = expected_roots.pop_front();
            if (got.root !== want.root)
                report_mismatch("root", longint'(signed'(want.root)),
                                longint'(signed'(got.root)));
            if (got.iters !== want.iters)
                report_mismatch("iterations", longint'(want.iters), longint'(got.iters));
            if (got.status !== want.status)
                report_mismatch("status", longint'(want.status), longint'(got.status));
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_we;
    logic [TOL_W-1:0]     cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;     // interval_low, interval_high
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;     // root, iterations, status, pad

    root_scoreboard sb = new();

    int     quiet_cycles = 0;
    int     sent_count;
    bit     sender_burst;
    longint crossings[3];
    bit     has_zero;
    longint zero_x;

    bisection_cubic_root_finder_core #(
        .MAX_ITERS(MAX_ITERS),
        .FRAC_BITS(FRAC_BITS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Finds where f changes sign between a and b, and looks around that spot
    // for a grid point where f is exactly zero.
    function automatic void locate_crossing(input longint a_in, input longint b_in,
                                            output longint cross_x);
        longint a;
        longint b;
        longint mid;
        longint x;
        int     sa;
        a  = a_in;
        b  = b_in;
        sa = sb.f_sign(a);
        while (b - a > 1) begin
            mid = (a + b) >>> 1;
            if (sb.f_sign(mid) == sa) a = mid;
            else b = mid;
        end
        cross_x = a;
        for (x = a - 16; x <= b + 16; x++) begin
            if (!has_zero && sb.f_sign(x) == 0) begin
                has_zero = 1'b1;
                zero_x   = x;
            end
        end
    endfunction

    function automatic longint fit_field(longint v);
        return (v < FIELD_MIN) ? FIELD_MIN : ((v > FIELD_MAX) ? FIELD_MAX : v);
    endfunction

    // Mostly intervals around a root with random widths, some tight ones around
    // an exact zero (else the first crossing), and the rest raw random bit patterns.
    function automatic void pick_interval(output logic [IN_W-1:0] lo,
                                          output logic [IN_W-1:0] hi);
        int     kind;
        int     e;
        longint centre;
        longint a;
        longint b;
        longint t;
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
            if (kind < 45) begin
                centre = crossings[$urandom_range(0, 2)];
                e      = $urandom_range(0, 27);
            end else begin
                centre = has_zero ? zero_x : crossings[0];
                e      = $urandom_range(0, 6);
            end
            a = fit_field(centre - longint'($urandom_range(0, 1 << e)));
            b = fit_field(centre + longint'($urandom_range(1, 1 << e)));
            if ($urandom_range(0, 6) == 0) begin
                t = a;
                a = b;
                b = t;
            end
            lo = a[IN_W-1:0];
            hi = b[IN_W-1:0];
        end else begin
            lo = IN_W'($urandom());
            hi = IN_W'($urandom());
        end
    endfunction

    task automatic send_interval(input logic [IN_W-1:0] lo, input logic [IN_W-1:0] hi);
        int gap;
        if (sent_count % 32 == 0) sender_burst = ($urandom_range(0, 9) < 3);
        gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {hi, lo};
        do @(posedge aclk); while (!s_tready);
        sb.note_interval(lo, hi);
        sent_count++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] value);
        repeat (2) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.set_tolerance(value);
    endtask

    initial begin : result_sink
        int stall;
        int taken;
        bit burst;
        m_tready = 1'b0;
        taken    = 0;
        burst    = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (taken % 40 == 0) burst = ($urandom_range(0, 9) < 3);
            stall = burst ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata);
            taken++;
        end
    end

    initial begin : stimulus
        logic [IN_W-1:0]  lo;
        logic [IN_W-1:0]  hi;
        logic [TOL_W-1:0] tol_plan[8];
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        sent_count   = 0;
        sender_burst = 1'b0;
        has_zero     = 1'b0;
        zero_x       = 0;

        locate_crossing(0, ONE, crossings[0]);
        locate_crossing(-2 * ONE, -ONE, crossings[1]);
        locate_crossing(2 * ONE, 3 * ONE, crossings[2]);

        // Wide and tiny tolerances, zero among them, then a few in between.
        tol_plan[0] = 25'd1;
        tol_plan[1] = 25'd0;
        tol_plan[2] = 25'd16777216;
        tol_plan[3] = 25'h1FFFFFF;
        tol_plan[4] = TOL_W'($urandom_range(1, 64));
        tol_plan[5] = TOL_W'($urandom_range(1, 16777216));
        tol_plan[6] = TOL_RESET;
        tol_plan[7] = TOL_W'($urandom_range(1, 1024));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed intervals under the reset tolerance.
        send_interval(IN_W'(0), IN_W'(ONE));
        send_interval(IN_W'(-2 * ONE), IN_W'(-ONE));
        send_interval(IN_W'(2 * ONE), IN_W'(3 * ONE));
        send_interval(IN_W'(3 * ONE), IN_W'(4 * ONE));
        send_interval(IN_W'(FIELD_MIN), IN_W'(FIELD_MAX));
        send_interval(IN_W'(FIELD_MAX), IN_W'(FIELD_MIN));
        send_interval(IN_W'(ONE), IN_W'(0));
        send_interval(IN_W'(7 * ONE), IN_W'(-8 * ONE));
        send_interval(IN_W'(FIELD_MIN), IN_W'(FIELD_MIN));
        send_interval(IN_W'(FIELD_MAX), IN_W'(FIELD_MAX));
        send_interval(IN_W'(0), IN_W'(0));
        send_interval(IN_W'(-1), IN_W'(-1));
        send_interval(IN_W'(0), IN_W'(-1));
        send_interval(28'h5555555, 28'hAAAAAAA);
        send_interval(IN_W'(crossings[0]), IN_W'(crossings[0] + 1));
        send_interval(IN_W'(crossings[1] - 1), IN_W'(crossings[1] + 2));
        send_interval(IN_W'(crossings[2] + 3), IN_W'(crossings[2] - 3));
        if (has_zero) begin
            send_interval(IN_W'(zero_x), IN_W'(zero_x));
            send_interval(IN_W'(zero_x - 1000), IN_W'(zero_x + 1000));
            send_interval(IN_W'(zero_x - 5), IN_W'(zero_x + 7));
        end

        // Each phase waits for the core to go idle before the tolerance changes.
        for (int p = 0; p < 8; p++) begin
            drain_results();
            write_tolerance(tol_plan[p]);
            repeat (ITEMS_PER_PHASE) begin
                pick_interval(lo, hi);
                send_interval(lo, hi);
            end
        end

        drain_results();
        repeat (BUSY_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
rtl/bcrf_pkg.sv
rtl/bcrf_useq.sv
rtl/bisection_cubic_root_finder_core.sv
rtl/bcrf_checker.sv
tb/tb_bisection_cubic_root_finder_core.sv
